// ===== hdl/jhd_pkg.sv =====
// shared types and constants for the jpeg huffman table loader and decoder
// no dependencies
package jhd_pkg;

    localparam int CodeLengths = 16;
    localparam int Slots       = 8;
    localparam int Entries     = Slots * CodeLengths;
    localparam int SymDepth    = Slots * 256;
    localparam logic [15:0] MinSegLen = 16'd19;
    localparam logic [15:0] MinTableBytes = 16'd17;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_LO,
        PH_CLASS_ID,
        PH_COUNTS,
        PH_SYMBOLS
    } t_phase;

    typedef enum logic [1:0] {
        ST_SYMBOL   = 2'd0,
        ST_LOADED   = 2'd1,
        ST_BAD      = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // per length table entry
    typedef struct packed {
        logic [15:0] max_code;
        logic [15:0] min_code;
        logic [7:0]  offset;
    } t_entry;

    // table writes from the loader
    typedef struct packed {
        logic        tbl_we;
        logic [6:0]  tbl_addr;
        t_entry      tbl_data;
        logic        clr;
        logic [2:0]  clr_table;
        logic        sym_we;
        logic [10:0] sym_addr;
        logic [7:0]  sym_data;
    } t_load_wr;

    typedef struct packed {
        logic    valid;
        t_status status;
        logic [4:0] len;
    } t_result;

endpackage

// ===== hdl/jhd_loader.sv =====
// segment parser: builds canonical min/max codes and symbol offsets
// depends on jhd_pkg
module jhd_loader #(
    parameter int TABLES_PER_CLASS  = 4,
    parameter int SYMBOLS_PER_TABLE = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_seg_start,
    input  logic [7:0]        i_byte,
    input  logic [2:0]        i_tables_per_class,
    output jhd_pkg::t_load_wr o_wr,
    output jhd_pkg::t_result  o_res
);

    jhd_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_left, n_left;
    logic [2:0]  r_table, n_table;
    logic [4:0]  r_idx, n_idx;
    logic [16:0] r_acc, n_acc;
    logic [8:0]  r_expected, n_expected;
    logic [8:0]  r_written, n_written;

    logic [2:0]  w_limit;
    logic [9:0]  w_total;
    logic [17:0] w_accb;
    logic [17:0] w_bound;
    logic [15:0] w_left_dec;
    logic [15:0] w_len;
    logic [8:0]  w_wr_inc;
    logic [8:0]  w_exp_new;
    logic [16:0] w_acc_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= jhd_pkg::PH_IDLE;
            r_left     <= '0;
            r_table    <= '0;
            r_idx      <= '0;
            r_acc      <= '0;
            r_expected <= '0;
            r_written  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_left     <= n_left;
            r_table    <= n_table;
            r_idx      <= n_idx;
            r_acc      <= n_acc;
            r_expected <= n_expected;
            r_written  <= n_written;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_table    = r_table;
        n_idx      = r_idx;
        n_acc      = r_acc;
        n_expected = r_expected;
        n_written  = r_written;
        o_wr       = '0;
        o_res      = '0;
        w_limit    = (i_tables_per_class > 3'(TABLES_PER_CLASS)) ?
                     3'(TABLES_PER_CLASS) : i_tables_per_class;
        w_total    = {1'b0, r_expected} + {2'b0, i_byte};
        w_accb     = {1'b0, r_acc} + {10'b0, i_byte};
        w_bound    = 18'd1 << ({1'b0, r_idx[3:0]} + 5'd1);
        w_left_dec = r_left - 16'd1;
        w_len      = {r_left[15:8], i_byte};
        w_wr_inc   = r_written + 9'd1;
        w_exp_new  = (i_byte != 8'd0) ? w_total[8:0] : r_expected;
        w_acc_new  = ((i_byte != 8'd0) ? w_accb[16:0] : r_acc) << 1;
        o_wr.tbl_addr = {r_table, r_idx[3:0]};
        o_wr.tbl_data.min_code = r_acc[15:0];
        o_wr.tbl_data.max_code = w_accb[15:0] - 16'd1;
        o_wr.tbl_data.offset   = r_expected[7:0];
        o_wr.clr_table = {i_byte[4], i_byte[1:0]};
        o_wr.sym_addr  = {r_table, r_written[7:0]};
        o_wr.sym_data  = i_byte;
        if (i_en) begin
            if (i_seg_start) begin
                n_left  = {i_byte, 8'd0};
                n_phase = jhd_pkg::PH_LEN_LO;
            end else begin
                unique case (r_phase)
                    jhd_pkg::PH_LEN_LO: begin
                        if (w_len < jhd_pkg::MinSegLen) begin
                            n_phase = jhd_pkg::PH_IDLE;
                            n_left  = '0;
                            o_res   = '{1'b1, jhd_pkg::ST_BAD, 5'd0};
                        end else begin
                            n_left  = w_len - 16'd2;
                            n_phase = jhd_pkg::PH_CLASS_ID;
                        end
                    end
                    jhd_pkg::PH_CLASS_ID: begin
                        if (r_left < jhd_pkg::MinTableBytes || i_byte[7:4] > 4'd1 ||
                            i_byte[3:0] >= {1'b0, w_limit}) begin
                            n_phase = jhd_pkg::PH_IDLE;
                            n_left  = '0;
                            o_res   = '{1'b1, jhd_pkg::ST_BAD, 5'd0};
                        end else begin
                            n_left     = w_left_dec;
                            n_table    = o_wr.clr_table;
                            o_wr.clr   = 1'b1;
                            n_idx      = '0;
                            n_acc      = '0;
                            n_expected = '0;
                            n_written  = '0;
                            n_phase    = jhd_pkg::PH_COUNTS;
                        end
                    end
                    jhd_pkg::PH_COUNTS: begin
                        n_left = w_left_dec;
                        if (i_byte != 8'd0 && (w_accb > w_bound ||
                            w_total > 10'(SYMBOLS_PER_TABLE))) begin
                            n_phase = jhd_pkg::PH_IDLE;
                            n_left  = '0;
                            o_res   = '{1'b1, jhd_pkg::ST_BAD, 5'd0};
                        end else begin
                            o_wr.tbl_we = (i_byte != 8'd0);
                            n_expected  = w_exp_new;
                            n_acc       = w_acc_new;
                            n_idx       = r_idx + 5'd1;
                            if (r_idx[3:0] == 4'(jhd_pkg::CodeLengths - 1)) begin
                                if ({7'd0, w_exp_new} > w_left_dec) begin
                                    n_phase = jhd_pkg::PH_IDLE;
                                    n_left  = '0;
                                    o_res   = '{1'b1, jhd_pkg::ST_BAD, 5'd0};
                                end else if (w_exp_new == 9'd0) begin
                                    if (w_left_dec == 16'd0) begin
                                        n_phase = jhd_pkg::PH_IDLE;
                                        o_res   = '{1'b1, jhd_pkg::ST_LOADED, 5'd0};
                                    end else begin
                                        n_phase = jhd_pkg::PH_CLASS_ID;
                                    end
                                end else begin
                                    n_phase = jhd_pkg::PH_SYMBOLS;
                                end
                            end
                        end
                    end
                    jhd_pkg::PH_SYMBOLS: begin
                        o_wr.sym_we = 1'b1;
                        n_written   = w_wr_inc;
                        n_left      = w_left_dec;
                        if (w_wr_inc >= r_expected) begin
                            if (w_left_dec == 16'd0) begin
                                n_phase = jhd_pkg::PH_IDLE;
                                o_res   = '{1'b1, jhd_pkg::ST_LOADED, 5'd0};
                            end else begin
                                n_phase = jhd_pkg::PH_CLASS_ID;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/jhd_decoder.sv =====
// table store and bit serial decoder: entry memory with prefetch, symbol memory
// depends on jhd_pkg
module jhd_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_en,
    input  logic              i_bit,
    input  logic [2:0]        i_sel,
    input  jhd_pkg::t_load_wr i_wr,
    output jhd_pkg::t_result  o_res,
    output logic [7:0]        o_sym
);

    jhd_pkg::t_entry r_mem [jhd_pkg::Entries];
    jhd_pkg::t_entry r_k0 [jhd_pkg::Slots];
    jhd_pkg::t_entry r_pf_data;
    logic [7:0]  r_sym_mem [jhd_pkg::SymDepth];
    logic [jhd_pkg::Entries-1:0] r_present, n_present;
    logic [6:0]  r_pf, n_pf;
    logic [15:0] r_code, n_code;
    logic [4:0]  r_bits, n_bits;
    logic [2:0]  r_table, n_table;
    logic [10:0] w_sym_addr;

    jhd_pkg::t_entry w_e;
    logic        w_pres;
    logic        w_match;
    logic [4:0]  w_len;
    logic [7:0]  w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_pf      <= '0;
            r_code    <= '0;
            r_bits    <= '0;
            r_table   <= '0;
        end else begin
            r_present <= n_present;
            r_pf      <= n_pf;
            r_code    <= n_code;
            r_bits    <= n_bits;
            r_table   <= n_table;
        end
    end

    // entry memory, read data follows the prefetch address with write forwarding
    always_ff @(posedge i_clk) begin
        if (i_wr.tbl_we) begin
            r_mem[i_wr.tbl_addr] <= i_wr.tbl_data;
        end
        if (i_wr.tbl_we && i_wr.tbl_addr == n_pf) begin
            r_pf_data <= i_wr.tbl_data;
        end else begin
            r_pf_data <= r_mem[n_pf];
        end
    end

    // first length entries in flops so a new code needs no prefetch
    always_ff @(posedge i_clk) begin
        if (i_wr.tbl_we && i_wr.tbl_addr[3:0] == 4'd0) begin
            r_k0[i_wr.tbl_addr[6:4]] <= i_wr.tbl_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.sym_we) begin
            r_sym_mem[i_wr.sym_addr] <= i_wr.sym_data;
        end
        if (i_accept) begin
            o_sym <= r_sym_mem[w_sym_addr];
        end
    end

    always_comb begin
        n_present = r_present;
        if (i_wr.clr) begin
            n_present[{i_wr.clr_table, 4'd0} +: jhd_pkg::CodeLengths] = '0;
        end
        if (i_wr.tbl_we) begin
            n_present[i_wr.tbl_addr] = 1'b1;
        end
        if (r_bits == 5'd0) begin
            n_table = i_sel;
            n_code  = {15'd0, i_bit};
            w_e     = r_k0[i_sel];
            w_pres  = r_present[{i_sel, 4'd0}];
        end else begin
            n_table = r_table;
            n_code  = {r_code[14:0], i_bit};
            w_e     = r_pf_data;
            w_pres  = r_present[{r_table, r_bits[3:0]}];
        end
        w_len   = r_bits + 5'd1;
        w_match = w_pres && n_code <= w_e.max_code && n_code >= w_e.min_code;
        w_idx   = w_e.offset + n_code[7:0] - w_e.min_code[7:0];
        w_sym_addr = {n_table, w_idx};
        o_res   = '0;
        if (w_match) begin
            o_res = '{1'b1, jhd_pkg::ST_SYMBOL, w_len};
        end else if (w_len == 5'(jhd_pkg::CodeLengths)) begin
            o_res = '{1'b1, jhd_pkg::ST_NOTFOUND, 5'd0};
        end
        n_bits = o_res.valid ? 5'd0 : w_len;
        n_pf   = {n_table, n_bits[3:0]};
        if (!i_en) begin
            o_res   = '0;
            n_table = r_table;
            n_code  = r_code;
            n_bits  = r_bits;
            n_pf    = r_pf;
        end
    end

endmodule

// ===== hdl/jpeg_huffman_table_load_and_decode.sv =====
// top level of the jpeg huffman table loader and bit serial decoder
// depends on jhd_pkg, jhd_loader, jhd_decoder
//
// usage:
//   slave stream: one word per item; tuser says whether tdata carries a segment
//   byte (mode 0) or a coded bit (mode 1) and marks the first length byte of a
//   segment. master stream: one word per result (symbol, segment loaded, bad
//   segment, code not found); bits and bytes that finish nothing give no word.
//   apb port: register 0 at byte address 0 holds tables_per_class.
// throughput: one word per cycle while tready is high, segment bytes and coded bits
//   alike; a code's first bit is compared against an entry held in flops, each later
//   one against its length's entry, read ahead from the table memory into a register.
// output path: a result is registered with the symbol memory read, then in the
//   output register, before it shows on the master side.
// stall: the output register and the stage before it keep taking words until
//   both are full; tready then drops until the receiver takes the result.
// reset: synchronous, tables read as empty, parser idle, no code in progress;
//   no clearing pass is needed.
module jpeg_huffman_table_load_and_decode #(
    parameter int TABLES_PER_CLASS  = 4,
    parameter int SYMBOLS_PER_TABLE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // data_value[7:0], table_select[10:8], zero
    input  logic [1:0]  s_axis_tuser,  // mode[0], segment_start[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // symbol[7:0], code_length[12:8], zero
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0] r_tpc;
    logic       w_accept;
    logic       w_move;

    jhd_pkg::t_load_wr w_wr;
    jhd_pkg::t_result  w_lres;
    jhd_pkg::t_result  w_dres;
    logic [7:0]        w_sym;

    // stage after accept: waits on the symbol memory read
    logic       r_s1_valid;
    logic [1:0] r_s1_status;
    logic [4:0] r_s1_len;
    // output register
    logic       r_o_valid;
    logic [7:0] r_o_sym;
    logic [4:0] r_o_len;
    logic [1:0] r_o_status;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {29'd0, r_tpc} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpc <= 3'(TABLES_PER_CLASS);
        end else if (psel && penable && pwrite && paddr == 3'd0) begin
            r_tpc <= pwdata[2:0];
        end
    end

    assign w_move        = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_move;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    jhd_loader #(
        .TABLES_PER_CLASS (TABLES_PER_CLASS),
        .SYMBOLS_PER_TABLE(SYMBOLS_PER_TABLE)
    ) u_loader (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_accept && !s_axis_tuser[0]),
        .i_seg_start       (s_axis_tuser[1]),
        .i_byte            (s_axis_tdata[7:0]),
        .i_tables_per_class(r_tpc),
        .o_wr              (w_wr),
        .o_res             (w_lres)
    );

    jhd_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_en    (w_accept && s_axis_tuser[0]),
        .i_bit   (s_axis_tdata[0]),
        .i_sel   (s_axis_tdata[10:8]),
        .i_wr    (w_wr),
        .o_res   (w_dres),
        .o_sym   (w_sym)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= w_lres.valid || w_dres.valid;
            end else if (w_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_move) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= w_lres.valid ? w_lres.status : w_dres.status;
            r_s1_len    <= w_lres.valid ? 5'd0 : w_dres.len;
        end
        if (w_move) begin
            r_o_status <= r_s1_status;
            r_o_len    <= r_s1_len;
            r_o_sym    <= (r_s1_status == jhd_pkg::ST_SYMBOL) ? w_sym : 8'd0;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {3'd0, r_o_len, r_o_sym};
    assign m_axis_tuser  = r_o_status;

endmodule

// ===== verif/huffman_decode_checker.sv =====
// result checker for the jpeg huffman table loader and decoder: tracks apb writes and
// both stream channels, predicts every result word and compares it in order
// depends on jhd_pkg
module huffman_decode_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // data_value[7:0], table_select[10:8], zero
    input  logic [1:0]  s_axis_tuser,  // mode[0], segment_start[1]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,  // symbol[7:0], code_length[12:8], zero
    input  logic [1:0]  m_axis_tuser,  // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]       sym;
        logic [4:0]       len;
        jhd_pkg::t_status status;
    } t_outcome;

    t_outcome    due_results[$];

    logic [2:0]  ids_allowed;
    logic [16:0] max_code[jhd_pkg::Entries];
    logic [15:0] min_code[jhd_pkg::Entries];
    logic [7:0]  first_sym[jhd_pkg::Entries];
    logic [7:0]  sym_mem[jhd_pkg::SymDepth];
    jhd_pkg::t_phase phase;
    int          bytes_left;
    int          ld_slot;
    int          ld_len;
    int          code_acc;
    int          sym_total;
    int          sym_count;
    int          code;
    int          nbits;
    int          dec_slot;

    initial o_errors = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    task automatic push_outcome(input logic [7:0] s, input logic [4:0] l,
                                input jhd_pkg::t_status st);
        t_outcome r;
        r.sym = s;
        r.len = l;
        r.status = st;
        due_results.push_back(r);
    endtask

    task automatic reject_segment();
        phase = jhd_pkg::PH_IDLE;
        bytes_left = 0;
        push_outcome(8'd0, 5'd0, jhd_pkg::ST_BAD);
    endtask

    task automatic table_end();
        if (bytes_left == 0) begin
            phase = jhd_pkg::PH_IDLE;
            push_outcome(8'd0, 5'd0, jhd_pkg::ST_LOADED);
        end else begin
            phase = jhd_pkg::PH_CLASS_ID;
        end
    endtask

    task automatic take_segment_byte(input logic start, input logic [7:0] b);
        int lim;
        int k;
        int e;
        int total;
        int len;
        if (start) begin
            bytes_left = int'(b) << 8;
            phase = jhd_pkg::PH_LEN_LO;
        end else begin
            case (phase)
                jhd_pkg::PH_LEN_LO: begin
                    len = (bytes_left & 16'hFF00) | int'(b);
                    if (len < int'(jhd_pkg::MinSegLen)) begin
                        reject_segment();
                    end else begin
                        bytes_left = len - 2;
                        phase = jhd_pkg::PH_CLASS_ID;
                    end
                end
                jhd_pkg::PH_CLASS_ID: begin
                    lim = (ids_allowed > 4) ? 4 : int'(ids_allowed);
                    if (bytes_left < int'(jhd_pkg::MinTableBytes) || b[7:4] > 1 ||
                        int'(b[3:0]) >= lim) begin
                        reject_segment();
                    end else begin
                        bytes_left--;
                        ld_slot = int'(b[4]) * 4 + int'(b[1:0]);
                        for (k = 0; k < jhd_pkg::CodeLengths; k++)
                            max_code[ld_slot * 16 + k] = '0;
                        ld_len = 0;
                        code_acc = 0;
                        sym_total = 0;
                        sym_count = 0;
                        phase = jhd_pkg::PH_COUNTS;
                    end
                end
                jhd_pkg::PH_COUNTS: begin
                    k = ld_len & 15;
                    e = ld_slot * 16 + k;
                    total = sym_total + int'(b);
                    bytes_left--;
                    if (b != 0 && (code_acc + int'(b) > (1 << (k + 1)) || total > 256)) begin
                        reject_segment();
                    end else begin
                        if (b != 0) begin
                            min_code[e] = code_acc[15:0];
                            max_code[e] = {1'b1, 16'(code_acc + int'(b) - 1)};
                            first_sym[e] = sym_total[7:0];
                            code_acc += int'(b);
                            sym_total = total;
                        end
                        code_acc = (code_acc << 1) & 17'h1FFFF;
                        ld_len = k + 1;
                        if (ld_len == jhd_pkg::CodeLengths) begin
                            if (sym_total > bytes_left) reject_segment();
                            else if (sym_total == 0) table_end();
                            else phase = jhd_pkg::PH_SYMBOLS;
                        end
                    end
                end
                jhd_pkg::PH_SYMBOLS: begin
                    sym_mem[ld_slot * 256 + (sym_count & 255)] = b;
                    sym_count++;
                    bytes_left--;
                    if (sym_count >= sym_total) table_end();
                end
                default: ;
            endcase
        end
    endtask

    task automatic take_code_bit(input logic bit_in, input logic [2:0] sel);
        int e;
        int idx;
        int len;
        if (nbits == 0) begin
            dec_slot = int'(sel);
            code = int'(bit_in);
        end else begin
            code = ((code << 1) | int'(bit_in)) & 16'hFFFF;
        end
        nbits++;
        len = nbits;
        e = dec_slot * 16 + ((len - 1) & 15);
        if (max_code[e][16] && code <= int'(max_code[e][15:0]) &&
            code >= int'(min_code[e])) begin
            idx = (int'(first_sym[e]) + code - int'(min_code[e])) & 255;
            nbits = 0;
            push_outcome(sym_mem[dec_slot * 256 + idx], 5'(len), jhd_pkg::ST_SYMBOL);
        end else if (len >= jhd_pkg::CodeLengths) begin
            nbits = 0;
            push_outcome(8'd0, 5'd0, jhd_pkg::ST_NOTFOUND);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            ids_allowed = 3'd4;
            foreach (max_code[i]) begin
                max_code[i] = '0;
                min_code[i] = '0;
                first_sym[i] = '0;
            end
            foreach (sym_mem[i]) sym_mem[i] = '0;
            phase = jhd_pkg::PH_IDLE;
            bytes_left = 0;
            ld_slot = 0;
            ld_len = 0;
            code_acc = 0;
            sym_total = 0;
            sym_count = 0;
            code = 0;
            nbits = 0;
            dec_slot = 0;
            due_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'd0) ids_allowed = pwdata[2:0];
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0]) take_code_bit(s_axis_tdata[0], s_axis_tdata[10:8]);
                else take_segment_byte(s_axis_tuser[1], s_axis_tdata[7:0]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("word with nothing expected, status", int'(m_axis_tuser), -1);
                end else begin
                    want = due_results.pop_front();
                    if (m_axis_tuser != want.status)
                        report_mismatch("status", int'(m_axis_tuser), int'(want.status));
                    if (m_axis_tdata[7:0] != want.sym)
                        report_mismatch("symbol", int'(m_axis_tdata[7:0]), int'(want.sym));
                    if (m_axis_tdata[12:8] != want.len)
                        report_mismatch("code length", int'(m_axis_tdata[12:8]), int'(want.len));
                end
            end
        end
        o_pending <= due_results.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// top of the testbench for jpeg_huffman_table_load_and_decode: clock, reset, apb
// writes, segment and coded bit stimulus, receiver stalls and the verdict
// depends on the block and huffman_decode_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;  // data_value[7:0], table_select[10:8], zero
    logic [1:0]  s_axis_tuser = '0;  // mode[0], segment_start[1]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // symbol[7:0], code_length[12:8], zero
    logic [1:0]  m_axis_tuser;       // status[1:0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;

    // one segment byte waiting to go out; mark 1 makes its slot unsafe to
    // decode from, mark 2 makes it safe again once the table is complete
    typedef struct {
        logic       start;
        logic [7:0] data;
        int         mark;
        int         slot;
    } t_seg_byte;

    localparam int MarkUnsafe = 1;
    localparam int MarkSafe   = 2;
    localparam int HoldStart  = 700;
    localparam int HoldCycles = 300;
    localparam int StallLimit = 4000;

    t_seg_byte seg_bytes[$];
    t_seg_byte seg_body[$];
    bit        slot_ok[8];
    int        dec_slot = 7;
    int        guard_slot = 0;
    int        guard_left = 0;
    int        id_limit = 4;
    int        burst_left = 0;
    int        n_sent = 0;
    bit        need_start = 0;
    bit        hold_done = 0;
    int        hold_left = 0;
    int        rx_tick = 0;
    int        rx_style = 0;
    int        stall_cycles = 0;

    jpeg_huffman_table_load_and_decode dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    huffman_decode_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: one long hold-off after HoldStart sends, else a style picked
    // at random at regular points (always ready, coin flip, mostly stalled)
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && n_sent >= HoldStart) begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            m_axis_tready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (rx_tick % 64 == 0) rx_style <= $urandom_range(0, 2);
            case (rx_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog on cycles where no word moves on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= StallLimit) begin
                $display("status: fail");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // sender: bursts of random length, random gaps between them; tready is
    // sampled on the falling edge so the accepting edge is known
    task automatic send_word(input bit mode, input bit start, input logic [7:0] data,
                             input logic [2:0] sel);
        bit ok;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, sel, data};
        s_axis_tuser <= {start, mode};
        do begin
            @(negedge i_clk);
            ok = s_axis_tready;
            @(posedge i_clk);
        end while (!ok);
        n_sent++;
    endtask

    task automatic send_code_bit();
        send_word(1'b1, 1'($urandom), 8'($urandom), 3'(dec_slot));
        if (guard_left > 0) guard_left--;
    endtask

    task automatic send_seg_byte();
        t_seg_byte w;
        w = seg_bytes.pop_front();
        if (w.mark == MarkUnsafe) slot_ok[w.slot] = 0;
        send_word(1'b0, w.start, w.data, 3'($urandom));
        if (w.mark == MarkSafe) slot_ok[w.slot] = 1;
    endtask

    // a slot that a table may be loaded into: legal id, not the one being
    // decoded, not one a code may still be running in
    function automatic int pick_slot();
        int cand[$];
        for (int s = 0; s < 8; s++)
            if (s % 4 < id_limit && s != dec_slot && !(guard_left > 0 && s == guard_slot))
                cand.push_back(s);
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    task automatic add_byte(input logic [7:0] d, input int mark = 0, input int slot = 0);
        seg_body.push_back('{1'b0, d, mark, slot});
    endtask

    // class/id byte, 16 counts, and the symbols when the table is to complete
    task automatic add_table(input int slot, input logic [7:0] cnt[16], input bit complete);
        int n;
        n = 0;
        foreach (cnt[k]) n += int'(cnt[k]);
        add_byte({3'b000, 1'(slot >> 2), 2'b00, 2'(slot)}, MarkUnsafe, slot);
        for (int k = 0; k < 16; k++)
            add_byte(cnt[k], (complete && k == 15 && n == 0) ? MarkSafe : 0, slot);
        if (complete)
            for (int i = 0; i < n; i++) add_byte(8'($urandom), (i == n - 1) ? MarkSafe : 0, slot);
    endtask

    // canonical counts that never overflow the code space
    task automatic make_counts(input int nsym, output logic [7:0] cnt[16]);
        int acc;
        int rem;
        int m;
        int c;
        acc = 0;
        rem = nsym;
        for (int l = 1; l <= 16; l++) begin
            m = (1 << l) - acc;
            if (rem < m) m = rem;
            if (m > 255) m = 255;
            c = (l == 16) ? m : $urandom_range(0, m);
            cnt[l - 1] = 8'(c);
            rem -= c;
            acc = (acc + c) * 2;
        end
    endtask

    task automatic close_segment(input int len);
        seg_bytes.push_back('{1'b1, 8'(len >> 8), 0, 0});
        seg_bytes.push_back('{1'b0, 8'(len), 0, 0});
        foreach (seg_body[i]) seg_bytes.push_back(seg_body[i]);
        seg_body.delete();
    endtask

    task automatic build_segment();
        int kind;
        int s;
        int n;
        int r;
        int len;
        logic [7:0] cnt[16];
        kind = $urandom_range(0, 19);
        s = pick_slot();
        if (kind == 19 && need_start) kind = 0;
        if (s < 0 && kind != 11 && kind != 13 && kind != 19) kind = 12;
        foreach (cnt[k]) cnt[k] = 8'd0;
        len = 0;
        case (kind)
            9: begin  // table with no codes
                add_table(s, cnt, 1);
                len = 19;
            end
            10: begin  // largest table, 256 symbols
                cnt[7] = 8'd128;
                cnt[8] = 8'd128;
                add_table(s, cnt, 1);
                len = 2 + 17 + 256;
            end
            11: len = $urandom_range(0, 18);  // short length
            12: begin  // class above 1
                add_byte({4'($urandom_range(2, 15)), 4'($urandom)});
                len = 19 + $urandom_range(0, 100);
            end
            13: begin  // id not legal
                add_byte({3'b000, 1'($urandom), 4'($urandom_range(id_limit, 15))});
                len = 19 + $urandom_range(0, 100);
            end
            14: begin  // code space overflow at one length
                r = $urandom_range(1, 7);
                cnt[r - 1] = 8'((1 << r) + $urandom_range(1, 5));
                add_table(s, cnt, 0);
                len = 2 + 17 + 50;
            end
            15: begin  // running total above 256
                cnt[8] = 8'd200;
                cnt[9] = 8'd100;
                add_table(s, cnt, 0);
                len = 2 + 17 + 300;
            end
            16: begin  // counts promise more symbols than bytes remain
                make_counts($urandom_range(1, 20), cnt);
                n = 0;
                foreach (cnt[k]) n += int'(cnt[k]);
                if (n == 0) begin
                    cnt[0] = 8'd1;
                    n = 1;
                end
                add_table(s, cnt, 0);
                len = 2 + 17 + n - 1;
            end
            17: begin  // second class/id byte with under 17 bytes left
                make_counts($urandom_range(1, 20), cnt);
                add_table(s, cnt, 1);
                r = $urandom_range(1, 16);
                add_byte({3'b000, 1'(s >> 2), 2'b00, 2'(s)});
                for (int i = 1; i < r; i++) add_byte(8'($urandom));
                len = seg_body.size() + 2;
            end
            18: begin  // long length, abandoned by the next segment start
                make_counts($urandom_range(1, 20), cnt);
                add_table(s, cnt, 1);
                if ($urandom_range(0, 1) == 1) begin
                    s = pick_slot();
                    add_byte({3'b000, 1'(s >> 2), 2'b00, 2'(s)}, MarkUnsafe, s);
                    for (int i = 0; i < 5; i++) add_byte(8'd0);
                end
                len = $urandom_range(seg_body.size() + 42, 65535);
            end
            19: begin  // stray bytes while idle
                for (int i = $urandom_range(1, 4); i > 0; i--)
                    seg_bytes.push_back('{1'b0, 8'($urandom), 0, 0});
            end
            default: begin  // well-formed segment of one to three tables
                for (int t = $urandom_range(1, 3); t > 0; t--) begin
                    if (s >= 0) begin
                        make_counts($urandom_range(1, 24), cnt);
                        add_table(s, cnt, 1);
                    end
                    s = pick_slot();
                end
                len = seg_body.size() + 2;
            end
        endcase
        if (kind != 19) begin
            close_segment(len);
            need_start = (kind == 18);
        end
    endtask

    task automatic switch_decode_slot();
        int cand[$];
        int s;
        for (int i = 0; i < 8; i++) if (slot_ok[i]) cand.push_back(i);
        s = cand[$urandom_range(0, cand.size() - 1)];
        if (s != dec_slot) begin
            // a code begun in the old slot may run up to 16 more bits
            guard_slot = dec_slot;
            guard_left = 16;
            dec_slot = s;
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = n_sent + count;
        while (n_sent < target) begin
            if (seg_bytes.size() == 0) begin
                if ($urandom_range(0, 3) == 0) build_segment();
                else if ($urandom_range(0, 4) == 0) switch_decode_slot();
            end
            if (seg_bytes.size() > 0 && $urandom_range(0, 2) != 0) send_seg_byte();
            else send_code_bit();
        end
        while (seg_bytes.size() > 0) send_seg_byte();
    endtask

    // register writes only with nothing in flight; the extra cycles cover
    // words still inside the block that produce no result
    task automatic set_limit(input int v);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (6) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'd0;
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        id_limit = (v > 4) ? 4 : v;
    endtask

    initial begin
        int limits[6];
        limits = '{1, 4, 2, 7, 0, 3};
        foreach (slot_ok[i]) slot_ok[i] = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_limit(4);

        // stray byte, short length, bad class, bad id, code overflow
        send_word(1'b0, 1'b0, 8'hA5, 3'd0);
        send_word(1'b0, 1'b1, 8'h00, 3'd0);
        send_word(1'b0, 1'b0, 8'h12, 3'd0);
        send_word(1'b0, 1'b1, 8'h00, 3'd0);
        send_word(1'b0, 1'b0, 8'h13, 3'd0);
        send_word(1'b0, 1'b0, 8'hF0, 3'd0);
        send_word(1'b0, 1'b1, 8'h00, 3'd0);
        send_word(1'b0, 1'b0, 8'h13, 3'd0);
        send_word(1'b0, 1'b0, 8'h1F, 3'd0);
        send_word(1'b0, 1'b1, 8'h00, 3'd0);
        send_word(1'b0, 1'b0, 8'h28, 3'd0);
        send_word(1'b0, 1'b0, 8'h00, 3'd0);
        send_word(1'b0, 1'b0, 8'h03, 3'd0);
        // empty slot: sixteen bits find nothing
        repeat (16) send_code_bit();

        foreach (limits[i]) begin
            set_limit(limits[i]);
            run_random(220);
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
